@@ src/olads_pkg.sv @@
// shared constants and control/status types for the ordered list unit
package olads_pkg;

	localparam int DEPTH_DEF = 64;

	// command codes
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	// status codes
	localparam logic [2:0] ST_INSERTED      = 3'd0;
	localparam logic [2:0] ST_FULL          = 3'd1;
	localparam logic [2:0] ST_DELETED       = 3'd2;
	localparam logic [2:0] ST_DEL_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FOUND         = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND     = 3'd5;
	localparam logic [2:0] ST_EMPTY         = 3'd6;

	typedef struct packed {
		logic       load;
		logic       alloc_fresh;
		logic       pop_rd;
		logic       pop_take;
		logic       node_wr;
		logic       tail_link;
		logic       walk_start;
		logic       walk_step;
		logic       unlink;
		logic       free_push;
		logic       set_rsp;
		logic [2:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic fresh_avail;
		logic match;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

@@ src/olads_ifs.sv @@
// request and response channel interfaces
interface olads_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  cmd;
	logic signed [31:0] data_value;

	modport source (output valid, output cmd, output data_value, input ready);
	modport sink (input valid, input cmd, input data_value, output ready);
endinterface

interface olads_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [6:0] entry_count;

	modport source (output valid, output status, output entry_count, input ready);
	modport sink (input valid, input status, input entry_count, output ready);
endinterface

@@ src/olads_ctrl.sv @@
// controller state machine sequencing append, delete and search
module olads_ctrl import olads_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_cmd,
	output logic       req_ready,
	input  dp_stat_t   stat,
	output dp_cmd_t    ctl
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_A_POPW   = 4'd2;
	localparam logic [3:0] S_A_WR     = 4'd3;
	localparam logic [3:0] S_A_LINK   = 4'd4;
	localparam logic [3:0] S_WALK     = 4'd5;
	localparam logic [3:0] S_D_UNLINK = 4'd6;
	localparam logic [3:0] S_D_FREE   = 4'd7;
	localparam logic [3:0] S_RESP     = 4'd8;

	logic [3:0] state_q, state_d;
	logic [2:0] code_q, code_d;
	logic [1:0] cmd_q;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		ctl     = '0;
		ctl.code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (cmd_q == CMD_APPEND) begin
					if (stat.full) begin
						code_d  = ST_FULL;
						state_d = S_RESP;
					end else if (stat.fresh_avail) begin
						ctl.alloc_fresh = 1'b1;
						state_d         = S_A_WR;
					end else begin
						// reuse a slot from the recycled chain
						ctl.pop_rd = 1'b1;
						state_d    = S_A_POPW;
					end
				end else if (stat.empty) begin
					code_d  = ST_EMPTY;
					state_d = S_RESP;
				end else begin
					ctl.walk_start = 1'b1;
					state_d        = S_WALK;
				end
			end
			S_A_POPW: begin
				ctl.pop_take = 1'b1;
				state_d      = S_A_WR;
			end
			S_A_WR: begin
				ctl.node_wr = 1'b1;
				state_d     = S_A_LINK;
			end
			S_A_LINK: begin
				ctl.tail_link = 1'b1;
				code_d        = ST_INSERTED;
				state_d       = S_RESP;
			end
			S_WALK: begin
				if (stat.match) begin
					if (cmd_q == CMD_DELETE) begin
						state_d = S_D_UNLINK;
					end else begin
						code_d  = ST_FOUND;
						state_d = S_RESP;
					end
				end else if (stat.last) begin
					code_d  = (cmd_q == CMD_DELETE) ? ST_DEL_NOT_FOUND : ST_NOT_FOUND;
					state_d = S_RESP;
				end else begin
					ctl.walk_step = 1'b1;
				end
			end
			S_D_UNLINK: begin
				ctl.unlink = 1'b1;
				state_d    = S_D_FREE;
			end
			S_D_FREE: begin
				ctl.free_push = 1'b1;
				code_d        = ST_DELETED;
				state_d       = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					ctl.set_rsp = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_INSERTED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req_cmd;
		end
	end

endmodule

@@ src/olads_dp.sv @@
// datapath: node memories, list pointers, walk registers and response register
module olads_dp import olads_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            ctl,
	output dp_stat_t           stat,
	input  logic signed [31:0] data_value,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output logic        [2:0]  status,
	output logic        [6:0]  entry_count
);

	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] node_value_mem [DEPTH];
	logic [SW-1:0]      node_link_mem [DEPTH];

	logic signed [31:0] value_q;
	logic signed [31:0] rd_value_q;
	logic [SW-1:0]      rd_link_q;
	logic [SW-1:0]      head_q, tail_q, free_head_q;
	logic [SW-1:0]      slot_q, cur_q, prev_q;
	logic [CW-1:0]      count_q, fresh_q, walk_n_q, walk_n_next;
	logic               rsp_valid_q;
	logic [2:0]         status_q;
	logic [6:0]         count_out_q;

	logic               rd_en;
	logic [SW-1:0]      rd_addr;
	logic               lnk_we;
	logic [SW-1:0]      lnk_wa, lnk_wd;

	assign walk_n_next = walk_n_q + CW'(1);

	assign stat.empty       = (count_q == '0);
	assign stat.full        = (count_q == CW'(DEPTH));
	assign stat.fresh_avail = (fresh_q != CW'(DEPTH));
	assign stat.match       = (rd_value_q == value_q);
	assign stat.last        = (walk_n_next == count_q);
	assign stat.out_free    = !rsp_valid_q || rsp_ready;

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_count = count_out_q;

	// read port: walk follows the link just read, one node a cycle
	always_comb begin
		rd_en   = ctl.walk_start | ctl.walk_step | ctl.pop_rd;
		rd_addr = head_q;
		if (ctl.walk_step) begin
			rd_addr = rd_link_q;
		end else if (ctl.pop_rd) begin
			rd_addr = free_head_q;
		end
	end

	// link write port, one writer per state
	always_comb begin
		lnk_we = 1'b0;
		lnk_wa = slot_q;
		lnk_wd = '0;
		if (ctl.node_wr) begin
			lnk_we = 1'b1;
		end else if (ctl.tail_link) begin
			lnk_we = !stat.empty;
			lnk_wa = tail_q;
			lnk_wd = slot_q;
		end else if (ctl.unlink) begin
			lnk_we = (walk_n_q != '0);
			lnk_wa = prev_q;
			lnk_wd = rd_link_q;
		end else if (ctl.free_push) begin
			// freed slot joins the recycled chain
			lnk_we = 1'b1;
			lnk_wa = cur_q;
			lnk_wd = free_head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (lnk_we) begin
			node_link_mem[lnk_wa] <= lnk_wd;
		end
		if (ctl.node_wr) begin
			node_value_mem[slot_q] <= value_q;
		end
		if (rd_en) begin
			rd_value_q <= node_value_mem[rd_addr];
			rd_link_q  <= node_link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= data_value;
		end
		if (ctl.alloc_fresh) begin
			slot_q <= fresh_q[SW-1:0];
		end else if (ctl.pop_take) begin
			slot_q <= free_head_q;
		end
		if (ctl.walk_start) begin
			cur_q    <= head_q;
			walk_n_q <= '0;
		end else if (ctl.walk_step) begin
			prev_q   <= cur_q;
			cur_q    <= rd_link_q;
			walk_n_q <= walk_n_next;
		end
		if (ctl.set_rsp) begin
			status_q    <= ctl.code;
			count_out_q <= 7'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			free_head_q <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.alloc_fresh) begin
				fresh_q <= fresh_q + CW'(1);
			end
			if (ctl.pop_take) begin
				free_head_q <= rd_link_q;
			end
			if (ctl.tail_link) begin
				if (stat.empty) begin
					head_q <= slot_q;
				end
				tail_q  <= slot_q;
				count_q <= count_q + CW'(1);
			end
			if (ctl.unlink) begin
				if (walk_n_q == '0) begin
					head_q <= rd_link_q;
				end else if (cur_q == tail_q) begin
					tail_q <= prev_q;
				end
			end
			if (ctl.free_push) begin
				free_head_q <= cur_q;
				count_q     <= count_q - CW'(1);
				if (count_q == CW'(1)) begin
					head_q <= '0;
					tail_q <= '0;
				end
			end
			if (ctl.set_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_vs_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fresh_q)
		else $error("more entries than slots ever handed out");

	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.walk_step |-> !stat.last && !stat.match)
		else $error("walk stepped past the last entry");

	a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.set_rsp |-> stat.out_free)
		else $error("pending response overwritten");

	a_recycle_only_when_used: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop_rd |-> !stat.fresh_avail && !stat.full)
		else $error("recycled chain used while fresh slots remain");

endmodule

@@ src/ordered_list_append_delete_search_unit.sv @@
// Ordered list unit: append on a full list, or delete/search on an empty one, goes straight
// to the response. Append writes the node, then links it at the tail; with no fresh slot left
// it reuses a deleted one, first read off the recycled chain. Search and delete walk the chain
// from the head, one node per cycle; a delete hit unlinks the node and frees its slot.
// A new request is taken the cycle after the result is registered, even while it waits.
// Reset clears pointers, counts and valid; node memories are not cleared, no sweep needed.
module ordered_list_append_delete_search_unit import olads_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	olads_req_if.sink   req,
	olads_rsp_if.source rsp
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	olads_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	olads_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.data_value  (req.data_value),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.status      (rsp.status),
		.entry_count (rsp.entry_count)
	);

endmodule
